/* design/spde_pkg.sv */
// Shared types and constants of the shadow page delta engine.
`default_nettype none
package spde_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int ADDR_BITS      = 48;
    localparam int OFF_BITS       = 12;
    localparam int COUNT_W        = 13;
    localparam int GROUP_BYTES    = 8;
    localparam int GRP_W          = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_DIFF  = 2'd1;
    localparam logic [1:0] MODE_APPLY = 2'd2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ADDR_BITS-1:0] page_addr;
        logic [2:0]           slot_sel;
        logic [OFF_BITS-1:0]  byte_offset;
        logic [7:0]           data_byte;
        logic                 mask_bit;
    } t_in;

    typedef struct packed {
        logic [2:0]         slot_out;
        logic               hit;
        logic               write_enable;
        logic [7:0]         out_byte;
        logic [7:0]         group_mask;
        logic               group_done;
        logic [COUNT_W-1:0] changed_count;
        logic               page_done;
        logic               need_send;
    } t_out;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage
`default_nettype wire

/* design/shadow_page_delta_engine.sv */
// Top level of the shadow page delta engine.
// Each transaction is taken in S_IDLE and executed in S_EXEC: in the cycle it is taken the
// shadow byte of the selected slot is read through the single read port of the shadow
// memory, and in S_EXEC the compare, the shadow write-back, the slot table update and the
// loading of the result register happen. S_EXEC waits while the result register still
// holds a result that has not been taken; no new transaction is taken while one waits
// there. The shadow memory is not cleared after reset, so the block is ready at once;
// shadow bytes read before being loaded hold unknown data.
`default_nettype none
module shadow_page_delta_engine #(
    parameter int SLOTS      = spde_pkg::SLOTS_DEF,
    parameter int PAGE_BYTES = spde_pkg::PAGE_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire spde_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output spde_pkg::t_out     o_out_data
);

    spde_pkg::t_cmd cmd;

    spde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    spde_dp #(
        .SLOTS      (SLOTS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .o_out   (o_out_data)
    );

endmodule
`default_nettype wire

/* design/spde_ctrl.sv */
// Controller: transaction handshake and two-step sequencing of each item.
`default_nettype none
module spde_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output spde_pkg::t_cmd     o_cmd
);

    spde_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spde_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            spde_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = spde_pkg::S_EXEC;
                end
            end
            spde_pkg::S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = spde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spde_pkg::S_IDLE;
            end
        endcase
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == spde_pkg::S_EXEC) && !o_in_ready)
        else $error("capture not followed by execute");

    a_rose_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit))
        else $error("result valid without commit");

    a_hold_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spde_pkg::S_EXEC) && r_out_valid && !i_out_ready
        |=> (r_state == spde_pkg::S_EXEC))
        else $error("commit while result register full");

endmodule
`default_nettype wire

/* design/spde_dp.sv */
// Datapath: slot table, ring pointer, shadow memory, diff bookkeeping, result register.
`default_nettype none
module spde_dp #(
    parameter int SLOTS      = spde_pkg::SLOTS_DEF,
    parameter int PAGE_BYTES = spde_pkg::PAGE_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire spde_pkg::t_cmd i_cmd,
    input  wire spde_pkg::t_in  i_in,
    output spde_pkg::t_out      o_out
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = SLOTS * PAGE_BYTES;
    localparam int MEM_W  = $clog2(DEPTH);

    function automatic logic [MEM_W-1:0] f_addr(input logic [SLOT_W-1:0] slot,
                                               input logic [spde_pkg::OFF_BITS-1:0] off);
        f_addr = MEM_W'(slot) * MEM_W'(PAGE_BYTES) + MEM_W'(off);
    endfunction

    logic [7:0]                     r_shadow [DEPTH];
    logic [7:0]                     r_rd_data;
    spde_pkg::t_in                  r_item;
    spde_pkg::t_out                 r_out;
    logic [spde_pkg::ADDR_BITS-1:0] r_slot_addr [SLOTS];
    logic [spde_pkg::ADDR_BITS-1:0] n_slot_addr [SLOTS];
    logic [SLOTS-1:0]               r_in_use, n_in_use;
    logic [SLOT_W-1:0]              r_ring, n_ring;
    logic [SLOT_W-1:0]              r_cur, n_cur;
    logic [7:0]                     r_mask, n_mask;
    logic [spde_pkg::COUNT_W-1:0]   r_cnt, n_cnt;

    spde_pkg::t_out                 res;
    logic                           op_ok;
    logic                           page_end;
    logic                           sel_ok;
    logic [SLOT_W-1:0]              sel_idx;
    logic [spde_pkg::GRP_W-1:0]     grp_bit;
    logic                           found;
    logic [SLOT_W-1:0]              hit_idx;
    logic                           used;
    logic                           changed;
    logic [7:0]                     mask_base;
    logic [spde_pkg::COUNT_W-1:0]   cnt_base;
    logic                           we;
    logic [SLOT_W-1:0]              wslot;

    assign op_ok    = (r_item.mode == spde_pkg::MODE_LOAD || r_item.mode == spde_pkg::MODE_DIFF
                       || r_item.mode == spde_pkg::MODE_APPLY)
                      && (int'(r_item.byte_offset) < PAGE_BYTES);
    assign page_end = (int'(r_item.byte_offset) == PAGE_BYTES - 1);
    assign sel_ok   = (int'(r_item.slot_sel) < SLOTS);
    assign sel_idx  = SLOT_W'(r_item.slot_sel);
    assign grp_bit  = r_item.byte_offset[spde_pkg::GRP_W-1:0];

    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_in_use[i] && r_slot_addr[i] == r_item.page_addr) begin
                found   = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_slot_addr = r_slot_addr;
        n_in_use    = r_in_use;
        n_ring      = r_ring;
        n_cur       = r_cur;
        n_mask      = r_mask;
        n_cnt       = r_cnt;
        res         = '0;
        we          = 1'b0;
        wslot       = r_cur;
        used        = 1'b0;
        changed     = 1'b0;
        mask_base   = (grp_bit == '0) ? 8'd0 : r_mask;
        cnt_base    = (r_item.byte_offset == '0) ? '0 : r_cnt;
        if (op_ok) begin
            res.page_done = page_end;
            case (r_item.mode)
                spde_pkg::MODE_LOAD: begin
                    if (r_item.byte_offset == '0) begin
                        wslot                = r_ring;
                        n_cur                = r_ring;
                        n_in_use[r_ring]     = 1'b1;
                        n_slot_addr[r_ring]  = r_item.page_addr;
                        n_ring = (int'(r_ring) == SLOTS - 1) ? '0 : r_ring + 1'b1;
                    end
                    we           = 1'b1;
                    res.slot_out = 3'(wslot);
                    res.hit      = 1'b1;
                end
                spde_pkg::MODE_DIFF: begin
                    used    = sel_ok && r_in_use[sel_idx];
                    changed = used && (r_rd_data != r_item.data_byte);
                    if (sel_ok) begin
                        n_cur = sel_idx;
                    end
                    wslot  = sel_idx;
                    we     = changed;
                    n_mask = mask_base | (changed ? (8'd1 << grp_bit) : 8'd0);
                    n_cnt  = (changed && cnt_base != spde_pkg::COUNT_MAX)
                             ? cnt_base + 1'b1 : cnt_base;
                    res.slot_out      = r_item.slot_sel;
                    res.hit           = used;
                    res.out_byte      = changed ? r_item.data_byte : 8'd0;
                    res.group_done    = (grp_bit == spde_pkg::GRP_W'(spde_pkg::GROUP_BYTES - 1));
                    res.group_mask    = res.group_done ? n_mask : 8'd0;
                    res.changed_count = n_cnt;
                    res.need_send     = page_end && (n_cnt != '0);
                end
                spde_pkg::MODE_APPLY: begin
                    wslot            = hit_idx;
                    we               = r_item.mask_bit && found;
                    res.slot_out     = 3'(hit_idx);
                    res.hit          = found;
                    res.write_enable = r_item.mask_bit;
                    res.out_byte     = r_item.mask_bit ? r_item.data_byte : 8'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_shadow[f_addr(SLOT_W'(i_in.slot_sel), i_in.byte_offset)];
        end
        if (i_cmd.commit && we) begin
            r_shadow[f_addr(wslot, r_item.byte_offset)] <= r_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.commit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_addr[i] <= '0;
            end
            r_in_use <= '0;
            r_ring   <= '0;
            r_cur    <= '0;
            r_mask   <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.commit) begin
            r_slot_addr <= n_slot_addr;
            r_in_use    <= n_in_use;
            r_ring      <= n_ring;
            r_cur       <= n_cur;
            r_mask      <= n_mask;
            r_cnt       <= n_cnt;
        end
    end

    assign o_out = r_out;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_ring) < SLOTS) && (int'(r_cur) < SLOTS))
        else $error("slot pointer out of range");

    a_load_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && op_ok && (r_item.mode == spde_pkg::MODE_LOAD)
        && (r_item.byte_offset == '0)
        |=> r_in_use[$past(r_ring)] && (r_cur == $past(r_ring)))
        else $error("load did not claim ring slot");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.capture && i_cmd.commit))
        else $error("capture and commit together");

endmodule
`default_nettype wire
